// File: src/stcl_pkg.sv
package stcl_pkg;

    // Line geometry: "HH:MM:SS,mmm --> HH:MM:SS,mmm".
    localparam logic [4:0] STAMP_LEN = 5'd12;
    localparam logic [4:0] ARROW_POS = 5'd12;
    localparam logic [4:0] END_POS   = 5'd17;
    localparam logic [4:0] LINE_LEN  = 5'd29;
    localparam logic [4:0] POS_MAX   = 5'd31;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_MINUTES   = 3'd2;
    localparam logic [2:0] ST_SECONDS   = 3'd3;
    localparam logic [2:0] ST_NOT_AFTER = 3'd4;
    localparam logic [2:0] ST_OVERLAP   = 3'd5;

    localparam logic [6:0] MAX_MIN_SEC = 7'd59;

    // One finished line as captured at its last byte.
    typedef struct packed {
        logic [30:0] start_fields;
        logic [30:0] end_fields;
        logic [2:0]  format_flags;
        logic        short_line;
        logic        fresh;
    } line_t;

    // A line after range checks and conversion to milliseconds.
    typedef struct packed {
        logic [2:0]  status;
        logic [28:0] start_ms;
        logic [28:0] end_ms;
        logic        fresh;
    } conv_t;

    typedef struct packed {
        logic [30:0] fields;
        logic        bad;
    } stamp_upd_t;

    // Fold one byte at local place q (0..11) into a stamp's digit fields.
    // Hours sit in bits 6:0, minutes 13:7, seconds 20:14, ms 30:21.
    function automatic stamp_upd_t stamp_update(input logic [30:0] f,
                                                input logic [3:0]  q,
                                                input logic [7:0]  c);
        stamp_upd_t  r;
        logic        digit;
        logic [3:0]  d;
        logic [10:0] acc7;
        logic [13:0] acc10;
        digit = (c >= 8'h30) && (c <= 8'h39);
        d     = digit ? c[3:0] : 4'd0;
        r.fields = f;
        r.bad    = 1'b0;
        acc7  = 11'd0;
        acc10 = 14'd0;
        case (q)
            4'd2, 4'd5: begin
                r.bad = (c != 8'h3A);
            end
            4'd8: begin
                r.bad = (c != 8'h2C);
            end
            4'd0, 4'd1: begin
                acc7 = {4'd0, f[6:0]} * 11'd10 + {7'd0, d};
                r.fields[6:0] = acc7[6:0];
                r.bad = !digit;
            end
            4'd3, 4'd4: begin
                acc7 = {4'd0, f[13:7]} * 11'd10 + {7'd0, d};
                r.fields[13:7] = acc7[6:0];
                r.bad = !digit;
            end
            4'd6, 4'd7: begin
                acc7 = {4'd0, f[20:14]} * 11'd10 + {7'd0, d};
                r.fields[20:14] = acc7[6:0];
                r.bad = !digit;
            end
            4'd9, 4'd10, 4'd11: begin
                acc10 = {4'd0, f[30:21]} * 14'd10 + {10'd0, d};
                r.fields[30:21] = acc10[9:0];
                r.bad = !digit;
            end
            default: begin
                r.bad = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Expected byte of the arrow " --> ".
    function automatic logic [7:0] arrow_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd1, 3'd2: ch = 8'h2D;
            3'd3:       ch = 8'h3E;
            default:    ch = 8'h20;
        endcase
        return ch;
    endfunction

    // Milliseconds of a stamp; 29 bits hold every 7-bit hour value.
    function automatic logic [28:0] to_ms(input logic [30:0] f);
        logic [28:0] h_ms;
        logic [28:0] m_ms;
        logic [28:0] s_ms;
        h_ms = {22'd0, f[6:0]}   * 29'd3600000;
        m_ms = {22'd0, f[13:7]}  * 29'd60000;
        s_ms = {22'd0, f[20:14]} * 29'd1000;
        return h_ms + m_ms + s_ms + {19'd0, f[30:21]};
    endfunction

    // Zero when minutes and seconds are in range, else the range status.
    function automatic logic [2:0] range_status(input logic [30:0] f);
        logic [2:0] st;
        if (f[13:7] > MAX_MIN_SEC) begin
            st = ST_MINUTES;
        end else if (f[20:14] > MAX_MIN_SEC) begin
            st = ST_SECONDS;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

// File: src/srt_timestamp_line_checker_unit.sv
// Timestamp line checker: takes one line byte per beat, one beat per cycle while s_ready is high.
// The result for a line passes in turn through the byte stage, the conversion stage
// and the result register, starting from the beat that carries its last byte;
// Bytes that end no line give no result; a stalled result stalls input only once
// the captured-line and conversion registers are also full.
// aresetn (synchronous, active low) clears line state and the previous end time.
module srt_timestamp_line_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_line_char,
    input  logic        s_line_end,
    input  logic        s_new_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [28:0] m_start_ms,
    output logic [28:0] m_end_ms
);

    logic            line_valid;
    logic            line_ready;
    stcl_pkg::line_t line_data;
    logic            conv_valid;
    logic            conv_ready;
    stcl_pkg::conv_t conv_data;

    // Byte checks and digit accumulation.
    stcl_byte_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_line_char (s_line_char),
        .s_line_end  (s_line_end),
        .s_new_file  (s_new_file),
        .line_valid  (line_valid),
        .line_ready  (line_ready),
        .line_o      (line_data)
    );

    // Range checks and millisecond conversion.
    stcl_time_convert u_convert (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_i     (line_data),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv_o     (conv_data)
    );

    // Ordering checks against the previous good line.
    stcl_order_check u_order (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv_i     (conv_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_start_ms (m_start_ms),
        .m_end_ms   (m_end_ms)
    );

endmodule

// File: src/stcl_byte_parser.sv
module stcl_byte_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_line_char,
    input  logic                s_line_end,
    input  logic                s_new_file,
    output logic                line_valid,
    input  logic                line_ready,
    output stcl_pkg::line_t     line_o
);

    logic [4:0]  pos_reg;
    logic [30:0] start_reg;
    logic [30:0] end_reg;
    logic [2:0]  flags_reg;
    logic        fresh_reg;
    logic        line_valid_reg;
    stcl_pkg::line_t line_reg;

    logic [30:0] start_next;
    logic [30:0] end_next;
    logic [2:0]  flags_next;
    logic [4:0]  pos_inc;
    logic [4:0]  end_q;
    logic [4:0]  arrow_q;
    logic        fresh_now;
    logic        accept;
    stcl_pkg::stamp_upd_t start_upd;
    stcl_pkg::stamp_upd_t end_upd;

    assign s_ready    = !line_valid_reg || line_ready;
    assign accept     = s_valid && s_ready;
    assign line_valid = line_valid_reg;
    assign line_o     = line_reg;

    // Per-byte check and digit accumulation at the current position.
    assign end_q     = pos_reg - stcl_pkg::END_POS;
    assign arrow_q   = pos_reg - stcl_pkg::ARROW_POS;
    assign start_upd = stcl_pkg::stamp_update(start_reg, pos_reg[3:0], s_line_char);
    assign end_upd   = stcl_pkg::stamp_update(end_reg, end_q[3:0], s_line_char);
    assign fresh_now = fresh_reg || ((pos_reg == 5'd0) && s_new_file);
    assign pos_inc   = (pos_reg == stcl_pkg::POS_MAX) ? pos_reg : pos_reg + 5'd1;

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        flags_next = flags_reg;
        if (pos_reg < stcl_pkg::STAMP_LEN) begin
            start_next    = start_upd.fields;
            flags_next[0] = flags_reg[0] | start_upd.bad;
        end else if (pos_reg < stcl_pkg::END_POS) begin
            flags_next[1] = flags_reg[1]
                          | (s_line_char != stcl_pkg::arrow_char(arrow_q[2:0]));
        end else if (pos_reg < stcl_pkg::LINE_LEN) begin
            end_next      = end_upd.fields;
            flags_next[2] = flags_reg[2] | end_upd.bad;
        end
    end

    // Line state: restarts after the last beat of a line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 5'd0;
            start_reg <= 31'd0;
            end_reg   <= 31'd0;
            flags_reg <= 3'd0;
            fresh_reg <= 1'b0;
        end else if (accept) begin
            if (s_line_end) begin
                pos_reg   <= 5'd0;
                start_reg <= 31'd0;
                end_reg   <= 31'd0;
                flags_reg <= 3'd0;
                fresh_reg <= 1'b0;
            end else begin
                pos_reg   <= pos_inc;
                start_reg <= start_next;
                end_reg   <= end_next;
                flags_reg <= flags_next;
                fresh_reg <= fresh_now;
            end
        end
    end

    // Captured line, handed to the conversion stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_valid_reg <= 1'b0;
        end else if (accept && s_line_end) begin
            line_valid_reg <= 1'b1;
        end else if (line_ready) begin
            line_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_line_end) begin
            line_reg.start_fields <= start_next;
            line_reg.end_fields   <= end_next;
            line_reg.format_flags <= flags_next;
            line_reg.short_line   <= (pos_inc < stcl_pkg::LINE_LEN);
            line_reg.fresh        <= fresh_now;
        end
    end

endmodule

// File: src/stcl_time_convert.sv
module stcl_time_convert (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                line_valid,
    output logic                line_ready,
    input  stcl_pkg::line_t     line_i,
    output logic                conv_valid,
    input  logic                conv_ready,
    output stcl_pkg::conv_t     conv_o
);

    logic            conv_valid_reg;
    stcl_pkg::conv_t conv_reg;
    logic [2:0]      status_next;
    logic [2:0]      start_range;
    logic [2:0]      end_range;

    assign line_ready = !conv_valid_reg || conv_ready;
    assign conv_valid = conv_valid_reg;
    assign conv_o     = conv_reg;

    // Format and range checks: short line, bad start or bad arrow, then start range, then end format, then end range.
    assign start_range = stcl_pkg::range_status(line_i.start_fields);
    assign end_range   = stcl_pkg::range_status(line_i.end_fields);

    always_comb begin
        if (line_i.short_line || (line_i.format_flags[1:0] != 2'b00)) begin
            status_next = stcl_pkg::ST_MALFORMED;
        end else if (start_range != stcl_pkg::ST_OK) begin
            status_next = start_range;
        end else if (line_i.format_flags[2]) begin
            status_next = stcl_pkg::ST_MALFORMED;
        end else begin
            status_next = end_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_valid_reg <= 1'b0;
        end else if (line_ready) begin
            conv_valid_reg <= line_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_ready && line_valid) begin
            conv_reg.status   <= status_next;
            conv_reg.start_ms <= stcl_pkg::to_ms(line_i.start_fields);
            conv_reg.end_ms   <= stcl_pkg::to_ms(line_i.end_fields);
            conv_reg.fresh    <= line_i.fresh;
        end
    end

endmodule

// File: src/stcl_order_check.sv
module stcl_order_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                conv_valid,
    output logic                conv_ready,
    input  stcl_pkg::conv_t     conv_i,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [28:0]         m_start_ms,
    output logic [28:0]         m_end_ms
);

    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [28:0] m_start_ms_reg;
    logic [28:0] m_end_ms_reg;
    logic [28:0] prev_end_reg;
    logic        have_prev_reg;
    logic        have_eff;
    logic        take;
    logic [2:0]  status_next;

    assign conv_ready = !m_valid_reg || m_ready;
    assign take       = conv_valid && conv_ready;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_start_ms = m_start_ms_reg;
    assign m_end_ms   = m_end_ms_reg;

    // A new file forgets the previous end before this line is judged.
    assign have_eff = have_prev_reg && !conv_i.fresh;

    always_comb begin
        if (conv_i.status != stcl_pkg::ST_OK) begin
            status_next = conv_i.status;
        end else if (conv_i.end_ms <= conv_i.start_ms) begin
            status_next = stcl_pkg::ST_NOT_AFTER;
        end else if (have_eff && (conv_i.start_ms < prev_end_reg)) begin
            status_next = stcl_pkg::ST_OVERLAP;
        end else begin
            status_next = stcl_pkg::ST_OK;
        end
    end

    // Previous end time moves only on a good line; a bad line that starts a new file clears it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_end_reg  <= 29'd0;
        end else if (take) begin
            if (status_next == stcl_pkg::ST_OK) begin
                have_prev_reg <= 1'b1;
                prev_end_reg  <= conv_i.end_ms;
            end else if (conv_i.fresh) begin
                have_prev_reg <= 1'b0;
                prev_end_reg  <= 29'd0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (conv_ready) begin
            m_valid_reg <= conv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_status_reg <= status_next;
            if (conv_i.status == stcl_pkg::ST_OK) begin
                m_start_ms_reg <= conv_i.start_ms;
                m_end_ms_reg   <= conv_i.end_ms;
            end else begin
                m_start_ms_reg <= 29'd0;
                m_end_ms_reg   <= 29'd0;
            end
        end
    end

endmodule
